// ----- rtl/iirtf_pkg.sv -----
package iirtf_pkg;

    // Filter order in use: 1 to MAX_ORDER delay words take part
    localparam int FILTER_ORDER = 3;
    localparam int MAX_ORDER    = 3;

    // Pin conversion: volts = (level - 30) * step, step in Q.24
    localparam logic signed [8:0]  PIN_ZERO      = 9'sd30;
    localparam logic signed [23:0] VOLT_STEP_Q24 = 24'sd377525;
    localparam logic [15:0]        FULL_SCALE    = 16'd40960;

    // Configuration register indexes
    localparam logic [2:0] REG_NUM_COEF_01   = 3'd0;
    localparam logic [2:0] REG_NUM_COEF_23   = 3'd1;
    localparam logic [2:0] REG_DEN_COEF_12   = 3'd2;
    localparam logic [2:0] REG_DEN_COEF_3    = 3'd3;
    localparam logic [2:0] REG_INPUT_GAIN    = 3'd4;
    localparam logic [2:0] REG_INPUT_OFFSET  = 3'd5;
    localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd6;
    localparam logic [2:0] REG_OUTPUT_OFFSET = 3'd7;

    // Register reset values
    localparam logic [31:0]        RST_NUM_COEF_01   = 32'd1184;
    localparam logic [31:0]        RST_NUM_COEF_23   = 32'd0;
    localparam logic [31:0]        RST_DEN_COEF_12   = 32'd57369;
    localparam logic signed [15:0] RST_DEN_COEF_3    = 16'sd0;
    localparam logic signed [23:0] RST_INPUT_GAIN    = 24'sd13107;
    localparam logic signed [23:0] RST_INPUT_OFFSET  = 24'sd0;
    localparam logic signed [23:0] RST_OUTPUT_GAIN   = 24'sd655;
    localparam logic signed [23:0] RST_OUTPUT_OFFSET = 24'sd2212;

    // Sequencer steps, one multiplier issue or accumulate per step
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VOLT,
        ST_GAIN_IN,
        ST_XSUM,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_W,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_B0,
        ST_Y,
        ST_GAIN_OUT,
        ST_FIN
    } state_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
        logic signed [31:0] r;
        if (v > 58'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -58'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Sign-extend a 16-bit coefficient to the multiplier's B width
    function automatic logic signed [23:0] coef24(input logic signed [15:0] c);
        return {{8{c[15]}}, c};
    endfunction

endpackage

// ----- rtl/iir_transfer_function_filter.sv -----
// Channel  Dir  Signals                       Word
// s_       in   s_tvalid s_tready s_tdata     tdata[7:0] pin_level
// m_       out  m_tvalid m_tready m_tdata     tdata[15:0] drive_volts, tuser[0] clamped
// cfg_     in   cfg_valid cfg_ready           cfg_index[2:0], cfg_data[31:0]
//
// Each sample runs through 14 sequencer steps from accept to result, then the
// block returns to idle; a new sample is accepted only while idle. The steps
// follow from the single shared 32x24 multiplier, whose product is registered.
// Reset clears the delay words and loads the register defaults.
// A result waits in the output register; the last step holds until it is taken.
// cfg_ready is always high; write only while the block is idle.
module iir_transfer_function_filter
    import iirtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pin_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] drive_volts
    output logic [0:0]  m_tuser,    // [0] clamped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    // Configuration registers
    logic [31:0]        num01_reg, num23_reg, den12_reg;
    logic signed [15:0] den3_reg;
    logic signed [23:0] in_gain_reg, in_off_reg, out_gain_reg, out_off_reg;

    // Filter state
    logic signed [31:0] dly_reg  [MAX_ORDER];
    logic signed [31:0] dly_next [MAX_ORDER];

    // Datapath
    logic [7:0]         lvl_reg, lvl_next;
    logic signed [55:0] prod_reg, prod_next;
    logic signed [57:0] acc_reg, acc_next;
    logic signed [31:0] hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_volts_reg, out_volts_next;
    logic               out_clamp_reg, out_clamp_next;

    // Shared multiplier
    logic signed [31:0] op_a;
    logic signed [23:0] op_b;
    logic signed [55:0] mul_res;
    logic               mul_en;

    // Coefficients, zero beyond the filter order
    logic signed [15:0] a_coef [MAX_ORDER];
    logic signed [15:0] b_coef [MAX_ORDER + 1];

    logic signed [8:0]  pin_off;
    logic signed [57:0] prod_ext;
    logic signed [57:0] volts_w, xsum_w, osum_w;
    logic signed [31:0] x_val, rnd_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_volts_reg;
    assign m_tuser   = out_clamp_reg;

    assign mul_res = op_a * op_b;

    // Coefficient unpacking with order gating
    always_comb
    begin
        a_coef[0] = den12_reg[15:0];
        a_coef[1] = (1 < FILTER_ORDER) ? den12_reg[31:16] : 16'sd0;
        a_coef[2] = (2 < FILTER_ORDER) ? den3_reg : 16'sd0;
        b_coef[0] = num01_reg[15:0];
        b_coef[1] = num01_reg[31:16];
        b_coef[2] = (1 < FILTER_ORDER) ? num23_reg[15:0] : 16'sd0;
        b_coef[3] = (2 < FILTER_ORDER) ? num23_reg[31:16] : 16'sd0;
    end

    // Rounded (half up) views of the product and accumulator
    assign pin_off  = $signed({1'b0, lvl_reg}) - PIN_ZERO;
    assign prod_ext = {{2{prod_reg[55]}}, prod_reg};
    assign volts_w  = (prod_ext + 58'sd1024) >>> 11;
    assign xsum_w   = ((prod_ext + 58'sd32768) >>> 16)
                      + $signed({{34{in_off_reg[23]}}, in_off_reg});
    assign osum_w   = ((prod_ext + 58'sd32768) >>> 16)
                      + $signed({{34{out_off_reg[23]}}, out_off_reg});
    assign x_val    = sat32(xsum_w);
    assign rnd_sat  = sat32((acc_reg + 58'sd4096) >>> 13);

    // Sequencer: next state, multiplier operands and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        out_volts_next = out_volts_reg;
        out_clamp_next = out_clamp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        for (int k = 0; k < MAX_ORDER; k++)
            dly_next[k] = dly_reg[k];
        op_a   = 32'sd0;
        op_b   = 24'sd0;
        mul_en = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lvl_next   = s_tdata;
                    state_next = ST_VOLT;
                end
            end
            ST_VOLT:
            begin
                op_a       = {{23{pin_off[8]}}, pin_off};
                op_b       = VOLT_STEP_Q24;
                mul_en     = 1'b1;
                state_next = ST_GAIN_IN;
            end
            ST_GAIN_IN:
            begin
                op_a       = volts_w[31:0];
                op_b       = in_gain_reg;
                mul_en     = 1'b1;
                state_next = ST_XSUM;
            end
            ST_XSUM:
            begin
                acc_next   = {{26{x_val[31]}}, x_val} <<< 13;
                op_a       = dly_reg[0];
                op_b       = coef24(a_coef[0]);
                mul_en     = 1'b1;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                acc_next   = acc_reg - prod_ext;
                op_a       = dly_reg[1];
                op_b       = coef24(a_coef[1]);
                mul_en     = 1'b1;
                state_next = ST_A2;
            end
            ST_A2:
            begin
                acc_next   = acc_reg - prod_ext;
                op_a       = dly_reg[2];
                op_b       = coef24(a_coef[2]);
                mul_en     = 1'b1;
                state_next = ST_A3;
            end
            ST_A3:
            begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_W;
            end
            ST_W:
            begin
                // w is kept in hold_reg until the delay line shifts
                hold_next  = rnd_sat;
                op_a       = dly_reg[0];
                op_b       = coef24(b_coef[1]);
                mul_en     = 1'b1;
                state_next = ST_B1;
            end
            ST_B1:
            begin
                acc_next   = prod_ext;
                op_a       = dly_reg[1];
                op_b       = coef24(b_coef[2]);
                mul_en     = 1'b1;
                state_next = ST_B2;
            end
            ST_B2:
            begin
                acc_next   = acc_reg + prod_ext;
                op_a       = dly_reg[2];
                op_b       = coef24(b_coef[3]);
                mul_en     = 1'b1;
                state_next = ST_B3;
            end
            ST_B3:
            begin
                acc_next   = acc_reg + prod_ext;
                op_a       = hold_reg;
                op_b       = coef24(b_coef[0]);
                mul_en     = 1'b1;
                state_next = ST_B0;
            end
            ST_B0:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_Y;
            end
            ST_Y:
            begin
                // Shift w into the delay line, keep y for the output gain
                dly_next[0] = hold_reg;
                for (int k = 1; k < MAX_ORDER; k++)
                begin
                    if (k < FILTER_ORDER)
                        dly_next[k] = dly_reg[k - 1];
                end
                hold_next  = rnd_sat;
                state_next = ST_GAIN_OUT;
            end
            ST_GAIN_OUT:
            begin
                op_a       = hold_reg;
                op_b       = out_gain_reg;
                mul_en     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Clamp to 0..5 V once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (osum_w < 58'sd0)
                    begin
                        out_volts_next = 16'd0;
                        out_clamp_next = 1'b1;
                    end
                    else if (osum_w > {42'd0, FULL_SCALE})
                    begin
                        out_volts_next = FULL_SCALE;
                        out_clamp_next = 1'b1;
                    end
                    else
                    begin
                        out_volts_next = osum_w[15:0];
                        out_clamp_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        prod_next = mul_en ? mul_res : prod_reg;
    end

    // Control state, delay words and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++)
                dly_reg[k] <= 32'sd0;
            num01_reg     <= RST_NUM_COEF_01;
            num23_reg     <= RST_NUM_COEF_23;
            den12_reg     <= RST_DEN_COEF_12;
            den3_reg      <= RST_DEN_COEF_3;
            in_gain_reg   <= RST_INPUT_GAIN;
            in_off_reg    <= RST_INPUT_OFFSET;
            out_gain_reg  <= RST_OUTPUT_GAIN;
            out_off_reg   <= RST_OUTPUT_OFFSET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < MAX_ORDER; k++)
                dly_reg[k] <= dly_next[k];
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NUM_COEF_01:   num01_reg    <= cfg_data;
                    REG_NUM_COEF_23:   num23_reg    <= cfg_data;
                    REG_DEN_COEF_12:   den12_reg    <= cfg_data;
                    REG_DEN_COEF_3:    den3_reg     <= cfg_data[15:0];
                    REG_INPUT_GAIN:    in_gain_reg  <= cfg_data[23:0];
                    REG_INPUT_OFFSET:  in_off_reg   <= cfg_data[23:0];
                    REG_OUTPUT_GAIN:   out_gain_reg <= cfg_data[23:0];
                    REG_OUTPUT_OFFSET: out_off_reg  <= cfg_data[23:0];
                    default:           num01_reg    <= num01_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        hold_reg      <= hold_next;
        out_volts_reg <= out_volts_next;
        out_clamp_reg <= out_clamp_next;
    end

endmodule
